[design/pca_pkg.sv]
// Shared types and constants for the Pearson correlation accumulator.
// No dependencies.
`timescale 1ns / 1ps

package pca_pkg;

    localparam int DEF_MAX_MEMBERS = 64;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_OP_W        = 2 * DEF_SAMPLE_BITS + 2 * 7 + 1;

    localparam int SAMPLE_W  = 16;
    localparam int CORR_W    = 16;
    localparam int CORR_FRAC = 14;
    localparam int ONE_Q14   = 1 << CORR_FRAC;
    localparam int QUOT_W    = 2 * CORR_FRAC + 3;
    localparam int ROOT_W    = CORR_FRAC + 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] ref_sample;
        logic signed [SAMPLE_W-1:0] field_sample;
        logic                       last_member;
    } pca_in_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic                     undefined_flag;
    } pca_out_t;

endpackage

[design/pca_mul.sv]
// Shift-add serial multiplier, one multiplier bit per cycle, unsigned operands.
// Depends on pca_pkg for the default operand width.
`timescale 1ns / 1ps

module pca_mul #(
    parameter int OP_W = pca_pkg::DEF_OP_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [OP_W-1:0]   op_a,
    input  logic [OP_W-1:0]   op_b,
    output logic              done,
    output logic [2*OP_W-1:0] product
);

    logic              busy_reg, busy_next;
    logic [2*OP_W-1:0] acc_reg, acc_next;
    logic [2*OP_W-1:0] mcand_reg, mcand_next;
    logic [OP_W-1:0]   mplier_reg, mplier_next;

    always_comb begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        done        = busy_reg && (mplier_reg == '0);
        if (start) begin
            busy_next   = 1'b1;
            acc_next    = '0;
            mcand_next  = (2*OP_W)'(op_a);
            mplier_next = op_b;
        end else if (busy_reg) begin
            if (mplier_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign product = acc_reg;

endmodule

[design/pearson_correlation_accumulator_top.sv]
// Top level of the Pearson correlation accumulator: sums, sequencer, divide, root.
// Depends on pca_pkg and pca_mul.
`timescale 1ns / 1ps
//
// Usage:
//   s_ channel takes one sample pair per item (reference, field, last flag).
//   m_ channel returns one item per series, on the pair marked last:
//   correlation in signed Q1.14 and undefined_flag for a zero variance.
//   A non-last pair is accepted, then accumulated with one SAMPLE_BITS x
//   SAMPLE_BITS multiplier used three times. Pairs past MAX_MEMBERS are
//   dropped, though a last one among them still closes the series.
//   A last pair adds the finish: 8 products on the serial multiplier with
//   operand width OP_W = 2*SAMPLE_BITS + 2*clog2(MAX_MEMBERS+1) + 1,
//   then a 31-bit restoring divide and a 16-bit square root.
//   s_ready is high only while the block is idle.
//   The result sits in an output register; a new series is accepted while it
//   waits. If the receiver stalls, the next finished result holds until the
//   register frees up.
//   Reset clears the sums, the count and the output valid.

module pearson_correlation_accumulator_top #(
    parameter int MAX_MEMBERS = pca_pkg::DEF_MAX_MEMBERS,
    parameter int SAMPLE_BITS = pca_pkg::DEF_SAMPLE_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pca_pkg::pca_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pca_pkg::pca_out_t m_data
);

    import pca_pkg::*;

    localparam int XW    = SAMPLE_BITS;
    localparam int NW    = $clog2(MAX_MEMBERS + 1);
    localparam int SXW   = XW + NW;
    localparam int SQW   = 2 * XW + NW;
    localparam int CW    = 2 * XW + 2 * NW + 1;
    localparam int PW    = 2 * CW;
    localparam int CNT_W = $clog2(QUOT_W);
    localparam int SRW   = ROOT_W + 4;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    issued_reg, issued_next;
    logic                    last_reg, last_next;
    logic signed [XW-1:0]    x_reg, x_next, y_reg, y_next;
    logic signed [2*XW-1:0]  prod_reg, prod_next;
    logic [NW-1:0]           count_reg, count_next;
    logic signed [SXW-1:0]   sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SQW-1:0]   sxy_reg, sxy_next, sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [CW-1:0]    tmp_reg, tmp_next, cov_reg, cov_next;
    logic signed [CW-1:0]    vx_reg, vx_next, vy_reg, vy_next;
    logic [PW-1:0]           p_reg, p_next, rem_reg, rem_next;
    logic                    c2lsb_reg, c2lsb_next;
    logic [QUOT_W-1:0]       quot_reg, quot_next;
    logic [2*ROOT_W-1:0]     src_reg, src_next;
    logic [SRW-1:0]          srem_reg, srem_next;
    logic [ROOT_W-1:0]       root_reg, root_next;
    pca_out_t                res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    pca_out_t                m_data_reg, m_data_next;

    logic [XW-1:0]           x_bits, y_bits;
    logic signed [XW-1:0]    ma, mb;
    logic signed [2*XW-1:0]  acc_mul;
    logic signed [CW-1:0]    opa_s, opb_s, pm, pv;
    logic [CW-1:0]           opa_mag, opb_mag;
    logic                    neg_prod;
    logic                    mul_start, mul_done;
    logic [PW-1:0]           mul_prod;
    logic                    var_bad;
    logic [PW:0]             div_sh, div_diff;
    logic                    div_ge;
    logic [SRW-1:0]          sq_sh, sq_trial;
    logic                    sq_ge;
    logic [ROOT_W:0]         qsum;
    logic [CORR_W-1:0]       qmag, qclamp;

    assign x_bits  = XW'(32'(unsigned'(s_data.ref_sample)));
    assign y_bits  = XW'(32'(unsigned'(s_data.field_sample)));

    assign ma      = (cnt_reg[1:0] == 2'd2) ? y_reg : x_reg;
    assign mb      = (cnt_reg[1:0] == 2'd1) ? x_reg : y_reg;
    assign acc_mul = ma * mb;

    always_comb begin
        case (cnt_reg[2:0])
            3'd0: begin
                opa_s = signed'(CW'(count_reg));
                opb_s = CW'(sxy_reg);
            end
            3'd1: begin
                opa_s = CW'(sx_reg);
                opb_s = CW'(sy_reg);
            end
            3'd2: begin
                opa_s = signed'(CW'(count_reg));
                opb_s = CW'(sxx_reg);
            end
            3'd3: begin
                opa_s = CW'(sx_reg);
                opb_s = CW'(sx_reg);
            end
            3'd4: begin
                opa_s = signed'(CW'(count_reg));
                opb_s = CW'(syy_reg);
            end
            3'd5: begin
                opa_s = CW'(sy_reg);
                opb_s = CW'(sy_reg);
            end
            3'd6: begin
                opa_s = vx_reg;
                opb_s = vy_reg;
            end
            default: begin
                opa_s = cov_reg;
                opb_s = cov_reg;
            end
        endcase
    end

    assign opa_mag  = opa_s[CW-1] ? unsigned'(-opa_s) : unsigned'(opa_s);
    assign opb_mag  = opb_s[CW-1] ? unsigned'(-opb_s) : unsigned'(opb_s);
    assign neg_prod = opa_s[CW-1] ^ opb_s[CW-1];
    assign pm       = signed'(mul_prod[CW-1:0]);
    assign pv       = neg_prod ? -pm : pm;
    assign var_bad  = vx_reg[CW-1] || (vx_reg == '0) || vy_reg[CW-1] || (vy_reg == '0);

    pca_mul #(
        .OP_W (CW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (opa_mag),
        .op_b    (opb_mag),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign div_sh   = {rem_reg, (cnt_reg == '0) ? c2lsb_reg : 1'b0};
    assign div_ge   = div_sh >= {1'b0, p_reg};
    assign div_diff = div_sh - {1'b0, p_reg};

    assign sq_sh    = {srem_reg[SRW-3:0], src_reg[2*ROOT_W-1 -: 2]};
    assign sq_trial = SRW'({root_reg, 2'b01});
    assign sq_ge    = sq_sh >= sq_trial;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        issued_next  = issued_reg;
        last_next    = last_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        prod_next    = prod_reg;
        count_next   = count_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        sxy_next     = sxy_reg;
        sxx_next     = sxx_reg;
        syy_next     = syy_reg;
        tmp_next     = tmp_reg;
        cov_next     = cov_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        p_next       = p_reg;
        rem_next     = rem_reg;
        c2lsb_next   = c2lsb_reg;
        quot_next    = quot_reg;
        src_next     = src_reg;
        srem_next    = srem_reg;
        root_next    = root_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mul_start    = 1'b0;
        qsum         = '0;
        qmag         = '0;
        qclamp       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    x_next    = signed'(x_bits);
                    y_next    = signed'(y_bits);
                    last_next = s_data.last_member;
                    cnt_next  = '0;
                    if (count_reg < NW'(MAX_MEMBERS)) begin
                        state_next = S_ACC;
                    end else if (s_data.last_member) begin
                        state_next  = S_MUL;
                        issued_next = 1'b0;
                    end
                end
            end
            S_ACC: begin
                cnt_next = cnt_reg + CNT_W'(1);
                case (cnt_reg[1:0])
                    2'd0: begin
                        prod_next  = acc_mul;
                        sx_next    = sx_reg + SXW'(x_reg);
                        sy_next    = sy_reg + SXW'(y_reg);
                        count_next = count_reg + NW'(1);
                    end
                    2'd1: begin
                        sxy_next  = sxy_reg + SQW'(prod_reg);
                        prod_next = acc_mul;
                    end
                    2'd2: begin
                        sxx_next  = sxx_reg + SQW'(prod_reg);
                        prod_next = acc_mul;
                    end
                    default: begin
                        syy_next = syy_reg + SQW'(prod_reg);
                        cnt_next = '0;
                        if (!last_reg) begin
                            state_next = S_IDLE;
                        end else if (count_reg == NW'(1)) begin
                            res_next.correlation    = CORR_W'(ONE_Q14);
                            res_next.undefined_flag = 1'b0;
                            state_next              = S_OUT;
                        end else begin
                            issued_next = 1'b0;
                            state_next  = S_MUL;
                        end
                    end
                endcase
            end
            S_MUL: begin
                if (!issued_reg) begin
                    if ((cnt_reg[2:0] == 3'd6) && var_bad) begin
                        res_next.correlation    = '0;
                        res_next.undefined_flag = 1'b1;
                        state_next              = S_OUT;
                    end else begin
                        mul_start   = 1'b1;
                        issued_next = 1'b1;
                    end
                end else if (mul_done) begin
                    issued_next = 1'b0;
                    cnt_next    = cnt_reg + CNT_W'(1);
                    case (cnt_reg[2:0])
                        3'd0:    tmp_next = pv;
                        3'd1:    cov_next = tmp_reg - pv;
                        3'd2:    tmp_next = pv;
                        3'd3:    vx_next  = tmp_reg - pv;
                        3'd4:    tmp_next = pv;
                        3'd5:    vy_next  = tmp_reg - pv;
                        3'd6:    p_next   = mul_prod;
                        default: begin
                            rem_next   = mul_prod >> 1;
                            c2lsb_next = mul_prod[0];
                            cnt_next   = '0;
                            state_next = S_DIV;
                        end
                    endcase
                end
            end
            S_DIV: begin
                rem_next  = div_ge ? div_diff[PW-1:0] : div_sh[PW-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], div_ge};
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    src_next   = (2*ROOT_W)'(quot_next);
                    srem_next  = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                srem_next = sq_ge ? (sq_sh - sq_trial) : sq_sh;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                src_next  = src_reg << 2;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    qsum   = {1'b0, root_next} + (ROOT_W+1)'(1);
                    qmag   = CORR_W'(qsum[ROOT_W:1]);
                    qclamp = (qmag > CORR_W'(ONE_Q14)) ? CORR_W'(ONE_Q14) : qmag;
                    res_next.correlation    = cov_reg[CW-1] ? -signed'(qclamp)
                                                            : signed'(qclamp);
                    res_next.undefined_flag = 1'b0;
                    cnt_next                = '0;
                    state_next              = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    count_next   = '0;
                    sx_next      = '0;
                    sy_next      = '0;
                    sxy_next     = '0;
                    sxx_next     = '0;
                    syy_next     = '0;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxy_reg     <= '0;
            sxx_reg     <= '0;
            syy_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sxy_reg     <= sxy_next;
            sxx_reg     <= sxx_next;
            syy_reg     <= syy_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        prod_reg   <= prod_next;
        tmp_reg    <= tmp_next;
        cov_reg    <= cov_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        p_reg      <= p_next;
        rem_reg    <= rem_next;
        c2lsb_reg  <= c2lsb_next;
        quot_reg   <= quot_next;
        src_reg    <= src_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/pca_checker.sv]
// Port-level checks for the Pearson correlation accumulator, bound to the top.
// Depends on pca_pkg and pearson_correlation_accumulator_top.
`timescale 1ns / 1ps

module pca_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input pca_pkg::pca_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input pca_pkg::pca_out_t m_data
);

    import pca_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.undefined_flag |-> m_data.correlation == '0)
        else $error("undefined result with nonzero correlation");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.correlation <= CORR_W'(ONE_Q14))
                 && (m_data.correlation >= -CORR_W'(ONE_Q14)))
        else $error("correlation out of range");

    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.last_member |=> !s_ready)
        else $error("ready right after a closing item");

endmodule

bind pearson_correlation_accumulator_top pca_checker u_pca_checker (.*);

[tb/tb_pearson_correlation_accumulator_top.sv]
// Testbench for pearson_correlation_accumulator_top: directed and random sample series,
// a scoreboard class with an exact wide-integer correlation predictor, and random handshakes.
// Depends on pca_pkg and the design top level.
`timescale 1ns / 1ps

class corr_scoreboard;
    pca_pkg::pca_out_t pending[$];
    int unsigned n_pairs;
    longint sx, sy, sxy, sxx, syy;
    int errors;
    int series_done;
    int flagged;
    int overfull;

    function void clear_sums();
        n_pairs = 0;
        sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
    endfunction

    function pca_pkg::pca_out_t close_series();
        pca_pkg::pca_out_t r;
        longint cov, vx, vy, n;
        bit [255:0] p, lhs, scaled, d, t;
        int unsigned lo, hi, mid;
        r.correlation = '0;
        r.undefined_flag = 1'b0;
        if (n_pairs == 1) begin
            r.correlation = 16'(pca_pkg::ONE_Q14);
            return r;
        end
        n = longint'(n_pairs);
        cov = n * sxy - sx * sy;
        vx = n * sxx - sx * sx;
        vy = n * syy - sy * sy;
        if (vx <= 0 || vy <= 0) begin
            r.undefined_flag = 1'b1;
            return r;
        end
        p = 256'(vx) * 256'(vy);
        scaled = 256'(cov < 0 ? -cov : cov) * 256'(2 * pca_pkg::ONE_Q14);
        lhs = scaled * scaled;
        lo = 0;
        hi = pca_pkg::ONE_Q14;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            d = 256'(2 * mid - 1);
            t = d * d * p;
            if (t <= lhs) lo = mid;
            else hi = mid - 1;
        end
        r.correlation = (cov < 0) ? -16'(lo) : 16'(lo);
        return r;
    endfunction

    function void note_pair(pca_pkg::pca_in_t it);
        longint x, y;
        pca_pkg::pca_out_t r;
        x = longint'(it.ref_sample);
        y = longint'(it.field_sample);
        if (n_pairs < pca_pkg::DEF_MAX_MEMBERS) begin
            n_pairs++;
            sx += x; sy += y;
            sxy += x * y; sxx += x * x; syy += y * y;
        end else if (it.last_member) begin
            overfull++;
        end
        if (it.last_member) begin
            r = close_series();
            pending = {pending, r};
            series_done++;
            if (r.undefined_flag) flagged++;
            clear_sums();
        end
    endfunction

    function void check_result(pca_pkg::pca_out_t got);
        pca_pkg::pca_out_t want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result corr=%0d flag=%0b", $time,
                     got.correlation, got.undefined_flag);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.correlation !== want.correlation) begin
            $display("%0t: correlation expected %0d actual %0d", $time,
                     want.correlation, got.correlation);
            errors++;
        end
        if (got.undefined_flag !== want.undefined_flag) begin
            $display("%0t: undefined_flag expected %0b actual %0b", $time,
                     want.undefined_flag, got.undefined_flag);
            errors++;
        end
    endfunction
endclass

module tb_pearson_correlation_accumulator_top;
    import pca_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pca_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pca_out_t m_data;

    corr_scoreboard sb = new();
    bit  quiet = 1'b0;
    int  items_sent = 0;
    longint cycle = 0;

    pearson_correlation_accumulator_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) cycle <= cycle + 1;

    // receiver: random ready, one long hold-off early in the random part
    always @(negedge aclk) begin
        if (cycle > 20000 && cycle < 24000) begin
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 19);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    task automatic send_pair(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic last);
        int gap;
        if (!quiet && $urandom_range(99) < 19) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data.ref_sample = x;
        s_data.field_sample = y;
        s_data.last_member = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_pair(s_data);
        items_sent++;
    endtask

    task automatic send_series(input int len, input int kind);
        logic signed [15:0] x, y, c;
        int i, k;
        c = 16'($urandom);
        k = $urandom_range(1, 3);
        for (i = 0; i < len; i++) begin
            case (kind)
                0: begin x = 16'($urandom); y = 16'($urandom); end
                1: begin
                    x = 16'(int'($urandom_range(0, 2000)) - 1000);
                    y = ($urandom_range(1)) ? 16'(int'(x) * k + int'($urandom_range(3)))
                                            : 16'(-int'(x) * k);
                end
                2: begin x = c; y = 16'($urandom); end
                3: begin
                    x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                    y = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
                end
                default: begin
                    x = 16'(int'($urandom_range(0, 15)) - 8);
                    y = 16'(int'($urandom_range(0, 15)) - 8);
                end
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial begin
        int len, kind, pick;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // single pair, extremes
        send_pair(16'sh8000, 16'sh7fff, 1'b1);
        // perfect positive
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        // perfect negative
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        // zero variance in x, then in y, then both
        send_pair(16'sh0005, 16'sh0001, 1'b0);
        send_pair(16'sh0005, 16'sh0009, 1'b1);
        send_pair(16'sh1234, 16'shffff, 1'b0);
        send_pair(-16'sh1234, 16'shffff, 1'b1);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b1);
        // uncorrelated-ish, rounding
        send_pair(16'sh0001, 16'sh0002, 1'b0);
        send_pair(16'sh0002, 16'sh0001, 1'b0);
        send_pair(16'sh0003, 16'sh0003, 1'b1);
        send_pair(16'shffff, 16'sh5555, 1'b0);
        send_pair(16'shaaaa, 16'sh0000, 1'b0);
        send_pair(16'sh7fff, 16'shffff, 1'b1);

        // full-size series once and an overlong one
        send_series(64, 0);
        send_series(75, 1);

        while (items_sent < 1350) begin
            quiet = (items_sent > 700 && items_sent < 900);
            pick = $urandom_range(99);
            if (pick < 4) len = $urandom_range(60, 80);
            else if (pick < 10) len = 1;
            else len = $urandom_range(2, 10);
            kind = $urandom_range(0, 4);
            send_series(len, kind);
        end
        quiet = 1'b0;
        @(negedge aclk);
        s_valid = 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("Sent %0d sample pairs in %0d series (%0d zero-variance, %0d overfull).",
                 items_sent, sb.series_done, sb.flagged, sb.overfull);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule
